// ===== design/opsc_pkg.sv =====
// Shared widths, command codes and interface structs for the odd-only prime sieve.
package opsc_pkg;

    // Field widths fixed by the stream and configuration formats
    localparam int CMD_W       = 2;
    localparam int NUM_W       = 18;
    localparam int LIMIT_W     = 18;
    localparam int CNT_W       = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 144;
    localparam int ITEM_W      = CMD_W + NUM_W;
    localparam int RESULT_W    = 1 + 8 * CNT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd131073;

    // Command codes carried in the cmd field
    localparam logic [CMD_W-1:0] CMD_SIEVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

    // One input item; cmd sits in the lowest bits
    typedef struct packed {
        logic [NUM_W-1:0] query_number;
        logic [CMD_W-1:0] cmd;
    } opsc_item_t;

    // One result item; number_is_prime sits in the lowest bit
    typedef struct packed {
        logic [CNT_W-1:0] quadruplet_candidates;
        logic [CNT_W-1:0] triplet_candidates;
        logic [CNT_W-1:0] twin_candidates;
        logic [CNT_W-1:0] quadruplet_hits;
        logic [CNT_W-1:0] triplet_two_hits;
        logic [CNT_W-1:0] triplet_one_hits;
        logic [CNT_W-1:0] twin_hits;
        logic [CNT_W-1:0] prime_count;
        logic             number_is_prime;
    } opsc_result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic sieve_start;
        logic fill_step;
        logic outer_init;
        logic p_read;
        logic inner_init;
        logic clear_step;
        logic outer_next;
        logic scan_sieve;
        logic count_start;
        logic scan_step;
        logic query_read;
        logic load_out;
    } opsc_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             map_valid;
        logic             lim_small;
        logic             fill_done;
        logic             pp_over;
        logic             p_bit;
        logic             n_over;
        logic             scan_done;
        logic             out_free;
    } opsc_stat_t;

endpackage

// ===== design/opsc_datapath.sv =====
// Datapath of the prime sieve: prime map memory, limit registers, loop counters and tallies.
module opsc_datapath #(
    parameter int ODD_ENTRIES = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  opsc_pkg::opsc_ctrl_t          ctl,
    output opsc_pkg::opsc_stat_t          stat,
    input  opsc_pkg::opsc_item_t          item,
    input  logic                          cfg_write,
    input  logic [opsc_pkg::LIMIT_W-1:0]  cfg_value,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output opsc_pkg::opsc_result_t        result
);
    import opsc_pkg::*;

    // Map address, limit, loop value and scan index widths
    localparam int AW = $clog2(ODD_ENTRIES);
    localparam int LW = $clog2(2 * ODD_ENTRIES + 2);
    localparam int EW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int NW = LW + 1;
    localparam int IW = AW + 1;
    localparam logic [EW-1:0] CAP = EW'(2 * ODD_ENTRIES + 1);

    // Prime map: entry i stands for the odd number 2*i+3
    logic mem [ODD_ENTRIES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [LW-1:0]      held_reg;
    logic [AW-1:0]      last_reg;
    logic               map_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      end_reg;
    logic               count_mode_reg;
    logic [NW-1:0]      p_reg;
    logic [NW-1:0]      pp_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      step_reg;
    logic               rd_valid_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               rd_in_reg;
    logic [3:0]         win_reg;
    opsc_result_t       acc_reg;
    opsc_result_t       acc_next;
    opsc_result_t       out_reg;
    opsc_result_t       out_next;
    logic               m_valid_reg;

    logic [EW-1:0] lim_ext;
    logic [EW-1:0] eff_ext;
    logic [AW-1:0] eff_last;
    logic [EW-1:0] held_ext;
    logic [NW-1:0] held_n;
    logic [IW-1:0] last_ext;
    logic [AW-1:0] p_idx;
    logic [AW-1:0] n_idx;
    logic [EW-1:0] num_ext;
    logic          q_in;
    logic          q_two;
    logic          q_odd;
    logic [AW-1:0] q_idx;
    logic          scan_in;
    logic          new_bit;
    logic [4:0]    nw;

    // Effective limit saturates at the top of the map
    always_comb
    begin
        lim_ext  = EW'(limit_reg);
        eff_ext  = (lim_ext < CAP) ? lim_ext : CAP;
        eff_last = (eff_ext >= EW'(3)) ? AW'((eff_ext - EW'(3)) >> 1) : '0;
        held_ext = EW'(held_reg);
        held_n   = NW'(held_reg);
        last_ext = IW'(last_reg);
        p_idx    = AW'((p_reg - NW'(3)) >> 1);
        n_idx    = AW'((n_reg - NW'(3)) >> 1);
        num_ext  = EW'(num_reg);
        q_in     = map_valid_reg && (num_ext <= held_ext);
        q_two    = (num_ext == EW'(2));
        q_odd    = num_reg[0] && (num_ext >= EW'(3));
        q_idx    = AW'((num_ext - EW'(3)) >> 1);
        scan_in  = (idx_reg <= last_ext);
    end

    // Status toward the controller
    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.map_valid = map_valid_reg;
        stat.lim_small = (eff_ext < EW'(3));
        stat.fill_done = (idx_reg == last_ext);
        stat.pp_over   = (pp_reg > held_n);
        stat.p_bit     = mem_rdata_reg;
        stat.n_over    = (n_reg > held_n);
        stat.scan_done = (idx_reg == end_reg);
        stat.out_free  = !m_valid_reg || m_tready;
    end

    // Memory port selection: one write and one read per cycle
    always_comb
    begin
        mem_we    = ctl.fill_step || ctl.clear_step;
        mem_waddr = ctl.fill_step ? AW'(idx_reg) : n_idx;
        mem_wdata = ctl.fill_step;
        mem_re    = ctl.p_read || (ctl.scan_step && scan_in) ||
                    (ctl.query_read && q_in && q_odd);
        if (ctl.p_read)
        begin
            mem_raddr = p_idx;
        end
        else if (ctl.query_read)
        begin
            mem_raddr = q_idx;
        end
        else
        begin
            mem_raddr = AW'(idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Scan tally: a plain prime count for the sieve, a five-bit window for constellations
    always_comb
    begin
        new_bit  = rd_in_reg && mem_rdata_reg;
        nw       = {new_bit, win_reg};
        acc_next = acc_reg;
        if (ctl.sieve_start)
        begin
            acc_next             = '0;
            acc_next.prime_count = (eff_ext >= EW'(2)) ? CNT_W'(1) : '0;
        end
        if (ctl.count_start)
        begin
            acc_next = '0;
        end
        if (rd_valid_reg)
        begin
            if (!count_mode_reg)
            begin
                acc_next.prime_count = acc_reg.prime_count + CNT_W'(new_bit);
            end
            else if (nw[0])
            begin
                // The oldest window bit is p, the newest is p+8
                if ((rd_idx_reg - IW'(3)) <= last_ext)
                begin
                    acc_next.twin_candidates = acc_reg.twin_candidates + CNT_W'(1);
                    acc_next.twin_hits       = acc_reg.twin_hits + CNT_W'(nw[1]);
                end
                if ((rd_idx_reg - IW'(1)) <= last_ext)
                begin
                    acc_next.triplet_candidates = acc_reg.triplet_candidates + CNT_W'(1);
                    acc_next.triplet_one_hits   = acc_reg.triplet_one_hits +
                                                  CNT_W'(nw[1] & nw[3]);
                    acc_next.triplet_two_hits   = acc_reg.triplet_two_hits +
                                                  CNT_W'(nw[2] & nw[3]);
                end
                if (rd_idx_reg <= last_ext)
                begin
                    acc_next.quadruplet_candidates = acc_reg.quadruplet_candidates +
                                                     CNT_W'(1);
                    acc_next.quadruplet_hits       = acc_reg.quadruplet_hits +
                                                     CNT_W'(nw[1] & nw[3] & nw[4]);
                end
            end
        end
    end

    // Result formatting: fields a command does not produce stay zero
    always_comb
    begin
        out_next = '0;
        case (cmd_reg)
            CMD_SIEVE:
            begin
                out_next.prime_count = acc_reg.prime_count;
            end
            CMD_QUERY:
            begin
                out_next.number_is_prime = q_in && (q_two || (q_odd && mem_rdata_reg));
            end
            CMD_COUNT:
            begin
                out_next                 = acc_reg;
                out_next.prime_count     = '0;
                out_next.number_is_prime = 1'b0;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            map_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_value;
            end
            if (ctl.sieve_start)
            begin
                map_valid_reg <= 1'b1;
            end
            rd_valid_reg <= ctl.scan_step;
            if (ctl.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the loops
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= item.cmd;
            num_reg <= item.query_number;
        end
        if (ctl.sieve_start)
        begin
            held_reg <= LW'(eff_ext);
            last_reg <= eff_last;
            idx_reg  <= '0;
        end
        if (ctl.fill_step || ctl.scan_step)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (ctl.outer_init)
        begin
            p_reg  <= NW'(3);
            pp_reg <= NW'(9);
        end
        if (ctl.outer_next)
        begin
            pp_reg <= pp_reg + (p_reg << 2) + NW'(4);
            p_reg  <= p_reg + NW'(2);
        end
        if (ctl.inner_init)
        begin
            n_reg    <= pp_reg;
            step_reg <= p_reg << 1;
        end
        if (ctl.clear_step)
        begin
            n_reg <= n_reg + step_reg;
        end
        if (ctl.scan_sieve)
        begin
            idx_reg        <= '0;
            end_reg        <= last_ext;
            count_mode_reg <= 1'b0;
        end
        if (ctl.count_start)
        begin
            idx_reg        <= IW'(1);
            end_reg        <= last_ext + IW'(4);
            count_mode_reg <= 1'b1;
            win_reg        <= '0;
        end
        if (rd_valid_reg && count_mode_reg)
        begin
            win_reg <= nw[4:1];
        end
        rd_idx_reg <= idx_reg;
        rd_in_reg  <= scan_in;
        acc_reg    <= acc_next;
        if (ctl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign result   = out_reg;

endmodule

// ===== design/opsc_ctrl.sv =====
// Controller state machine sequencing the sieve, query and constellation count.
module opsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  opsc_pkg::opsc_stat_t stat,
    output opsc_pkg::opsc_ctrl_t ctl
);
    import opsc_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_FILL       = 4'd2;
    localparam logic [3:0] S_OUTER_CHK  = 4'd3;
    localparam logic [3:0] S_OUTER_TEST = 4'd4;
    localparam logic [3:0] S_INNER      = 4'd5;
    localparam logic [3:0] S_SCAN       = 4'd6;
    localparam logic [3:0] S_DRAIN      = 4'd7;
    localparam logic [3:0] S_QREAD      = 4'd8;
    localparam logic [3:0] S_FINISH     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and datapath commands
    always_comb
    begin
        ctl         = '0;
        state_next  = state_reg;
        s_tready    = (state_reg == S_IDLE);
        ctl.capture = s_tvalid && s_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_SIEVE:
                    begin
                        ctl.sieve_start = 1'b1;
                        state_next      = stat.lim_small ? S_FINISH : S_FILL;
                    end
                    CMD_QUERY:
                    begin
                        state_next = S_QREAD;
                    end
                    CMD_COUNT:
                    begin
                        ctl.count_start = 1'b1;
                        state_next      = stat.map_valid ? S_SCAN : S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FILL:
            begin
                // Mark every odd entry up to the limit as a candidate
                ctl.fill_step = 1'b1;
                if (stat.fill_done)
                begin
                    ctl.outer_init = 1'b1;
                    state_next     = S_OUTER_CHK;
                end
            end
            S_OUTER_CHK:
            begin
                if (stat.pp_over)
                begin
                    ctl.scan_sieve = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    ctl.p_read = 1'b1;
                    state_next = S_OUTER_TEST;
                end
            end
            S_OUTER_TEST:
            begin
                if (stat.p_bit)
                begin
                    ctl.inner_init = 1'b1;
                    state_next     = S_INNER;
                end
                else
                begin
                    ctl.outer_next = 1'b1;
                    state_next     = S_OUTER_CHK;
                end
            end
            S_INNER:
            begin
                // Strike p*p, p*p+2p, ... up to the limit
                if (stat.n_over)
                begin
                    ctl.outer_next = 1'b1;
                    state_next     = S_OUTER_CHK;
                end
                else
                begin
                    ctl.clear_step = 1'b1;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_QREAD:
            begin
                ctl.query_read = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/odd_prime_sieve_constellations.sv =====
// Top level of the odd-only prime sieve with constellation counters.
// The block holds one map bit per odd number up to the configured limit (capped at
// 2*ODD_ENTRIES+1) and takes one command at a time. A query reads at most one map bit.
// A sieve fills the map, then for each odd p with p*p at most L reads the bit of p and,
// when p is prime, strikes each multiple from p*p on, and last counts the primes, where
// L is the effective limit. A constellation count scans the map once. The map memory
// serves one write and one read per cycle and returns read data in the next cycle. A new
// command is taken as soon as the previous result sits in the output register, even if it
// is still waiting to be taken.
module odd_prime_sieve_constellations #(
    parameter int ODD_ENTRIES = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: cmd[1:0], query_number[19:2], zero padding[23:20]
    input  logic [opsc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: number_is_prime[0], prime_count[17:1], twin_hits[34:18],
    // triplet_one_hits[51:35], triplet_two_hits[68:52], quadruplet_hits[85:69],
    // twin_candidates[102:86], triplet_candidates[119:103],
    // quadruplet_candidates[136:120], zero padding[143:137]
    output logic [opsc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [opsc_pkg::LIMIT_W-1:0]      cfg_data
);
    import opsc_pkg::*;

    opsc_ctrl_t   ctl;
    opsc_stat_t   stat;
    opsc_item_t   item;
    opsc_result_t result;

    // The limit register takes a write in any cycle
    assign cfg_ready = 1'b1;
    assign item      = opsc_item_t'(s_tdata[ITEM_W-1:0]);
    assign m_tdata   = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result};

    opsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    opsc_datapath #(
        .ODD_ENTRIES (ODD_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .item      (item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .result    (result)
    );

endmodule

// ===== design/opsc_checker.sv =====
// Port-level checker for the prime sieve and its bind to the top level.
module opsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [opsc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import opsc_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Commands are taken one at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken before the first one finished");

    // No result can appear the cycle right after a transfer into an empty output
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without computation");

    // A positive query answer carries no counts
    a_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("query result mixed with count fields");

endmodule

bind odd_prime_sieve_constellations opsc_checker u_opsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
